FILE: hdl/ri2pc_pkg.sv
// ----------------------------------------------------------------------------
// ri2pc_pkg
// types, sine table builder and angle folding for the range image converter
// ----------------------------------------------------------------------------
package ri2pc_pkg;

  localparam logic [7:0] HDR_B0 = 8'h64;
  localparam logic [7:0] HDR_B1 = 8'h65;
  localparam logic [7:0] HDR_B2 = 8'h70;
  localparam logic [7:0] FINAL_SEQ = 8'h21;
  localparam int unsigned SIN_LAST = 450;
  localparam longint unsigned PI_Q30 = 64'd3373259369;
  localparam longint unsigned ONE_Q30 = 64'd1073741824;

  typedef enum logic [3:0] {
    S_IDLE, S_RSE, S_RCE, S_RSA, S_RCA, S_MC, S_MX, S_MY, S_FIN, S_OUT
  } state_t;

  typedef enum logic [1:0] {ROM_SE, ROM_CE, ROM_SA, ROM_CA} rom_sel_t;
  typedef enum logic [1:0] {MUL_RSE, MUL_RCE, MUL_CCA, MUL_CSA} mul_sel_t;

  typedef struct packed {
    logic     accept;
    rom_sel_t rom_sel;
    logic     cap_se;
    logic     cap_ce;
    logic     cap_sa;
    logic     cap_ca;
    mul_sel_t mul_sel;
    logic     st_z;
    logic     st_c;
    logic     st_x;
    logic     st_y;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic point;
    logic flag;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic       neg;
    logic [8:0] idx;
  } rom_addr_t;

  typedef logic [30:0] sin_tab_t [0:SIN_LAST];

  function automatic longint unsigned quarter_sin(input int unsigned k);
    longint unsigned x, x2, t, r;
    x = (longint'(k) * PI_Q30) / 900;
    x2 = (x * x) >> 30;
    t = ONE_Q30;
    t = ONE_Q30 - ((x2 * t) >> 30) / 156;
    t = ONE_Q30 - ((x2 * t) >> 30) / 110;
    t = ONE_Q30 - ((x2 * t) >> 30) / 72;
    t = ONE_Q30 - ((x2 * t) >> 30) / 42;
    t = ONE_Q30 - ((x2 * t) >> 30) / 20;
    t = ONE_Q30 - ((x2 * t) >> 30) / 6;
    r = (x * t) >> 30;
    if (r > ONE_Q30) begin
      r = ONE_Q30;
    end
    return r;
  endfunction

  function automatic sin_tab_t build_sin_tab();
    sin_tab_t tab;
    for (int i = 0; i <= SIN_LAST; i++) begin
      tab[i] = 31'(quarter_sin(i));
    end
    return tab;
  endfunction

  // angle in 0.2 degree units, below 7200, to table index and sign
  function automatic rom_addr_t fold_angle(input logic [12:0] u);
    logic [12:0] v;
    logic [12:0] r;
    rom_addr_t a;
    v = u;
    for (int i = 0; i < 3; i++) begin
      if (v >= 13'd1800) begin
        v = v - 13'd1800;
      end
    end
    if (v >= 13'd1350) begin
      r = v - 13'd1350;
      a.idx = 9'(13'd450 - r);
      a.neg = 1'b1;
    end else if (v >= 13'd900) begin
      r = v - 13'd900;
      a.idx = r[8:0];
      a.neg = 1'b1;
    end else if (v >= 13'd450) begin
      r = v - 13'd450;
      a.idx = 9'(13'd450 - r);
      a.neg = 1'b0;
    end else begin
      a.idx = v[8:0];
      a.neg = 1'b0;
    end
    return a;
  endfunction

endpackage

FILE: hdl/ri2pc_ctrl.sv
// ----------------------------------------------------------------------------
// ri2pc_ctrl
// sequencer for table reads, multiplies and result handoff
// ----------------------------------------------------------------------------
module ri2pc_ctrl import ri2pc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.rom_sel = ROM_SE;
    cmd.mul_sel = MUL_RSE;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (status.point) begin
            state_nxt = S_RSE;
          end else if (status.flag) begin
            state_nxt = S_OUT;
          end
        end
      end
      S_RSE: begin
        cmd.rom_sel = ROM_SE;
        state_nxt = S_RCE;
      end
      S_RCE: begin
        cmd.rom_sel = ROM_CE;
        cmd.cap_se = 1'b1;
        state_nxt = S_RSA;
      end
      S_RSA: begin
        cmd.rom_sel = ROM_SA;
        cmd.cap_ce = 1'b1;
        cmd.mul_sel = MUL_RSE;
        state_nxt = S_RCA;
      end
      S_RCA: begin
        cmd.rom_sel = ROM_CA;
        cmd.cap_sa = 1'b1;
        cmd.mul_sel = MUL_RCE;
        cmd.st_z = 1'b1;
        state_nxt = S_MC;
      end
      S_MC: begin
        cmd.cap_ca = 1'b1;
        cmd.st_c = 1'b1;
        state_nxt = S_MX;
      end
      S_MX: begin
        cmd.mul_sel = MUL_CCA;
        state_nxt = S_MY;
      end
      S_MY: begin
        cmd.mul_sel = MUL_CSA;
        cmd.st_x = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.st_y = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

FILE: hdl/ri2pc_dp.sv
// ----------------------------------------------------------------------------
// ri2pc_dp
// datagram parsing, range conversion, sine table, multiplier, output register
// ----------------------------------------------------------------------------
module ri2pc_dp import ri2pc_pkg::*; #(
  parameter int ROWS = 16,
  parameter int COLS = 1800
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [31:0]        in_data_word,
  input  logic               in_first_of_datagram,
  input  logic               in_last_of_datagram,
  input  cmd_t               cmd,
  output status_t            status,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_point_valid,
  output logic signed [31:0] out_coord_x,
  output logic signed [31:0] out_coord_y,
  output logic signed [31:0] out_coord_z,
  output logic [3:0]         out_ring,
  output logic [10:0]        out_column,
  output logic               out_sequence_error,
  output logic               out_frame_done
);

  localparam int RW = $clog2(ROWS + 1);
  localparam int CW = (COLS > 1) ? $clog2(COLS) : 1;
  localparam sin_tab_t SIN_TAB = build_sin_tab();

  logic [7:0]    exp_seq_r, exp_seq_nxt;
  logic          idd_r, idd_nxt;
  logic          fp_r, fp_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;

  logic          pt, serr, fdone;
  logic          conv_ok;
  logic [30:0]   conv_q;

  // float32 range to Q16.16
  always_comb begin
    logic [7:0]  e;
    logic [23:0] m;
    logic [8:0]  nsh;
    e = in_data_word[30:23];
    m = {1'b1, in_data_word[22:0]};
    nsh = 9'd134 - {1'b0, e};
    conv_ok = 1'b1;
    conv_q = '0;
    if (e == 8'hFF) begin
      conv_ok = (in_data_word[22:0] == '0) && !in_data_word[31];
      conv_q = 31'h7FFFFFFF;
    end else if (in_data_word[31] || in_data_word[30:0] == '0) begin
      conv_ok = 1'b0;
    end else if (e == 8'h00) begin
      conv_q = '0;
    end else if (e > 8'd141) begin
      conv_q = 31'h7FFFFFFF;
    end else if (e >= 8'd134) begin
      conv_q = 31'({7'd0, m} << (e - 8'd134));
    end else if (nsh >= 9'd32) begin
      conv_q = '0;
    end else begin
      conv_q = 31'(m >> nsh[4:0]);
    end
  end

  always_comb begin
    exp_seq_nxt = exp_seq_r;
    idd_nxt = idd_r;
    fp_nxt = fp_r;
    row_nxt = row_r;
    col_nxt = col_r;
    pt = 1'b0;
    serr = 1'b0;
    fdone = 1'b0;
    if (in_first_of_datagram) begin
      idd_nxt = 1'b0;
      fp_nxt = 1'b0;
      if (in_data_word[7:0] == HDR_B0 && in_data_word[15:8] == HDR_B1 &&
          in_data_word[23:16] == HDR_B2) begin
        if (in_data_word[31:24] == FINAL_SEQ) begin
          idd_nxt = 1'b1;
          fp_nxt = 1'b1;
        end else if (in_data_word[31:24] == exp_seq_r) begin
          idd_nxt = 1'b1;
          exp_seq_nxt = exp_seq_r + 8'd1;
        end else begin
          serr = 1'b1;
        end
      end
    end else if (idd_r && row_r < RW'(ROWS)) begin
      pt = conv_ok;
      if (col_r == CW'(COLS - 1)) begin
        col_nxt = '0;
        row_nxt = row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
    if (in_last_of_datagram) begin
      if (idd_nxt && fp_nxt) begin
        fdone = 1'b1;
        exp_seq_nxt = '0;
        row_nxt = '0;
        col_nxt = '0;
      end
      idd_nxt = 1'b0;
      fp_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_seq_r <= '0;
      idd_r <= 1'b0;
      fp_r <= 1'b0;
      row_r <= '0;
      col_r <= '0;
    end else if (cmd.accept) begin
      exp_seq_r <= exp_seq_nxt;
      idd_r <= idd_nxt;
      fp_r <= fp_nxt;
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  logic               pt_r, serr_r, fdone_r;
  logic [30:0]        rng_r;
  logic [12:0]        eu_r, au_r;
  logic [3:0]         ring_r;
  logic [10:0]        colo_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pt_r <= pt;
      serr_r <= serr;
      fdone_r <= fdone;
      rng_r <= conv_q;
      eu_r <= 13'(13'(row_r) * 13'd10 + 13'd1725);
      au_r <= 13'(13'(col_r) + 13'd901);
      ring_r <= 4'(row_r);
      colo_r <= 11'(col_r);
    end
  end

  rom_addr_t          rom_addr;
  logic [30:0]        rom_q;
  logic               rom_neg_r;
  logic signed [31:0] trig;

  always_comb begin
    case (cmd.rom_sel)
      ROM_SE:  rom_addr = fold_angle(eu_r);
      ROM_CE:  rom_addr = fold_angle(eu_r + 13'd450);
      ROM_SA:  rom_addr = fold_angle(au_r);
      default: rom_addr = fold_angle(au_r + 13'd450);
    endcase
  end

  always_ff @(posedge clk) begin
    rom_q <= SIN_TAB[rom_addr.idx];
    rom_neg_r <= rom_addr.neg;
  end

  assign trig = rom_neg_r ? -$signed({1'b0, rom_q}) : $signed({1'b0, rom_q});

  logic signed [31:0] se_r, ce_r, sa_r, ca_r;
  logic signed [31:0] c_r, x_r, y_r, z_r;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_q_r;
  logic signed [63:0] rnd;
  logic signed [31:0] tq;

  always_comb begin
    case (cmd.mul_sel)
      MUL_RSE: begin
        mul_a = $signed({1'b0, rng_r});
        mul_b = se_r;
      end
      MUL_RCE: begin
        mul_a = $signed({1'b0, rng_r});
        mul_b = ce_r;
      end
      MUL_CCA: begin
        mul_a = c_r;
        mul_b = ca_r;
      end
      default: begin
        mul_a = c_r;
        mul_b = sa_r;
      end
    endcase
  end

  assign rnd = mul_q_r + (mul_q_r[63] ? 64'sd1073741823 : 64'sd0);
  assign tq = 32'(rnd >>> 30);

  always_ff @(posedge clk) begin
    mul_q_r <= mul_a * mul_b;
    if (cmd.cap_se) se_r <= trig;
    if (cmd.cap_ce) ce_r <= trig;
    if (cmd.cap_sa) sa_r <= trig;
    if (cmd.cap_ca) ca_r <= trig;
    if (cmd.st_z) z_r <= tq;
    if (cmd.st_c) c_r <= tq;
    if (cmd.st_x) x_r <= tq;
    if (cmd.st_y) y_r <= tq;
  end

  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_point_valid <= pt_r;
      out_coord_x <= pt_r ? x_r : '0;
      out_coord_y <= pt_r ? y_r : '0;
      out_coord_z <= pt_r ? z_r : '0;
      out_ring <= pt_r ? ring_r : '0;
      out_column <= pt_r ? colo_r : '0;
      out_sequence_error <= serr_r;
      out_frame_done <= fdone_r;
    end
  end

  assign out_valid = out_valid_r;
  assign status.point = pt;
  assign status.flag = serr | fdone;
  assign status.out_free = !out_valid_r || out_ready;

endmodule

FILE: hdl/range_image_to_point_cloud_core.sv
// path: a point runs through RSE, RCE, RSA, RCA, MC, MX, MY, FIN and OUT; a flag-only
//   result goes from IDLE to OUT; throughput: one beat per cycle for words without a
//   result; a point keeps in_ready low over four sine table reads and four products
//   through one multiplier; a full output register holds the sequencer until it drains
// reset (synchronous, rst_n low) clears sequence, datagram state and row/column counters
// ----------------------------------------------------------------------------
// range_image_to_point_cloud_core
// depth datagram words in, Cartesian Q16.16 points out
// ----------------------------------------------------------------------------
module range_image_to_point_cloud_core import ri2pc_pkg::*; #(
  parameter int ROWS = 16,
  parameter int COLS = 1800
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        in_data_word,
  input  logic               in_first_of_datagram,
  input  logic               in_last_of_datagram,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_point_valid,
  output logic signed [31:0] out_coord_x,
  output logic signed [31:0] out_coord_y,
  output logic signed [31:0] out_coord_z,
  output logic [3:0]         out_ring,
  output logic [10:0]        out_column,
  output logic               out_sequence_error,
  output logic               out_frame_done
);

  cmd_t    cmd;
  status_t status;

  ri2pc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  ri2pc_dp #(.ROWS(ROWS), .COLS(COLS)) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_data_word         (in_data_word),
    .in_first_of_datagram (in_first_of_datagram),
    .in_last_of_datagram  (in_last_of_datagram),
    .cmd                  (cmd),
    .status               (status),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_point_valid      (out_point_valid),
    .out_coord_x          (out_coord_x),
    .out_coord_y          (out_coord_y),
    .out_coord_z          (out_coord_z),
    .out_ring             (out_ring),
    .out_column           (out_column),
    .out_sequence_error   (out_sequence_error),
    .out_frame_done       (out_frame_done)
  );

  a_out_has_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_point_valid || out_sequence_error || out_frame_done))
    else $error("result beat without any flag");

  a_seqerr_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_sequence_error) |-> (!out_point_valid && !out_frame_done))
    else $error("sequence error combined with other flags");

  a_nopoint_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_point_valid) |->
      (out_coord_x == 0 && out_coord_y == 0 && out_coord_z == 0 && out_column == 0))
    else $error("coordinates not cleared without point");

endmodule

FILE: tb/tb_range_image_to_point_cloud_core.sv
// ----------------------------------------------------------------------------
// tb_range_image_to_point_cloud_core
// Drives depth datagram words through the converter and checks every result
// beat against a local model of the sequence checks, the float to Q16.16
// conversion and the sine/cosine rotation. A directed table comes first,
// followed by a sequence wrap pass and random datagrams.
// Both handshakes stall at random.
// ----------------------------------------------------------------------------
module tb_range_image_to_point_cloud_core import ri2pc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NROWS = 16;
  localparam int NCOLS = 1800;

  typedef struct packed {
    logic               pv;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [3:0]         ring;
    logic [10:0]        col;
    logic               serr;
    logic               fdone;
  } point_t;

  typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_SEQERR, EXP_DONE} exp_kind_t;

  typedef struct {
    logic [31:0] word;
    logic        first;
    logic        last;
    exp_kind_t   kind;
  } row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [31:0]        in_data_word = '0;
  logic               in_first_of_datagram = 1'b0;
  logic               in_last_of_datagram = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_point_valid;
  logic signed [31:0] out_coord_x, out_coord_y, out_coord_z;
  logic [3:0]         out_ring;
  logic [10:0]        out_column;
  logic               out_sequence_error, out_frame_done;

  range_image_to_point_cloud_core #(.ROWS(NROWS), .COLS(NCOLS)) dut (.*);

  always #2 clk = ~clk;

  // converter state as tracked by the checker
  logic [7:0]  seq_expected;
  logic        in_depth, final_pkt;
  logic [4:0]  row_cnt;
  logic [10:0] col_cnt;

  point_t      point_q[$];
  int          errors = 0;
  bit          quiet = 1'b0;

  function automatic longint signed sin_quarter(input int unsigned k);
    longint unsigned divs[6] = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
    longint unsigned x, x2, t, r;
    x = (64'(k) * 64'd3373259369) / 64'd900;
    x2 = (x * x) >> 30;
    t = 64'd1073741824;
    for (int i = 0; i < 6; i++) t = 64'd1073741824 - ((x2 * t) >> 30) / divs[i];
    r = (x * t) >> 30;
    if (r > 64'd1073741824) r = 64'd1073741824;
    return longint'(r);
  endfunction

  function automatic longint signed sin_of(input int unsigned u);
    int unsigned q, rm;
    longint signed mag;
    u = u % 1800;
    q = u / 450;
    rm = u % 450;
    mag = q[0] ? sin_quarter(450 - rm) : sin_quarter(rm);
    return (q >= 2) ? -mag : mag;
  endfunction

  function automatic bit range_q16(input logic [31:0] w, output longint signed q);
    logic [7:0] e;
    logic [23:0] m;
    int sh;
    longint unsigned v;
    e = w[30:23];
    m = {1'b0, w[22:0]};
    q = 0;
    if (e == 8'hff) begin
      if (m != 0 || w[31]) return 1'b0;
      q = 64'h7fffffff;
      return 1'b1;
    end
    if (w[31] || (e == 0 && m == 0)) return 1'b0;
    if (e == 0) return 1'b1;
    m[23] = 1'b1;
    sh = int'(e) - 134;
    if (sh > 7) v = 64'h7fffffff;
    else if (sh >= 0) begin
      v = 64'(m) << sh;
      if (v > 64'h7fffffff) v = 64'h7fffffff;
    end else if (-sh >= 32) v = 0;
    else v = 64'(m) >> (-sh);
    q = longint'(v);
    return 1'b1;
  endfunction

  function automatic bit convert_word(input logic [31:0] w, input logic f, input logic l,
                                      output point_t p);
    bit emit;
    longint signed r, se, ce, sa, ca, c;
    int unsigned eu, au;
    emit = 1'b0;
    p = '0;
    if (f) begin
      in_depth = 1'b0;
      final_pkt = 1'b0;
      if (w[7:0] == HDR_B0 && w[15:8] == HDR_B1 && w[23:16] == HDR_B2) begin
        if (w[31:24] == FINAL_SEQ) begin
          in_depth = 1'b1;
          final_pkt = 1'b1;
        end else if (w[31:24] == seq_expected) begin
          in_depth = 1'b1;
          seq_expected = seq_expected + 8'd1;
        end else begin
          p.serr = 1'b1;
          emit = 1'b1;
        end
      end
    end else if (in_depth && row_cnt < NROWS) begin
      if (range_q16(w, r)) begin
        eu = (10 * row_cnt + 1725) % 1800;
        au = (col_cnt + 901) % 1800;
        se = sin_of(eu);
        ce = sin_of(eu + 450);
        sa = sin_of(au);
        ca = sin_of(au + 450);
        c = (r * ce) / 64'sd1073741824;
        p.pv = 1'b1;
        p.x = 32'((c * ca) / 64'sd1073741824);
        p.y = 32'((c * sa) / 64'sd1073741824);
        p.z = 32'((r * se) / 64'sd1073741824);
        p.ring = row_cnt[3:0];
        p.col = col_cnt;
        emit = 1'b1;
      end
      if (col_cnt == NCOLS - 1) begin
        col_cnt = '0;
        row_cnt = row_cnt + 5'd1;
      end else col_cnt = col_cnt + 11'd1;
    end
    if (l) begin
      if (in_depth && final_pkt) begin
        p.fdone = 1'b1;
        emit = 1'b1;
        seq_expected = '0;
        row_cnt = '0;
        col_cnt = '0;
      end
      in_depth = 1'b0;
      final_pkt = 1'b0;
    end
    return emit;
  endfunction

  function automatic logic [31:0] header(input logic [7:0] s);
    return {s, HDR_B2, HDR_B1, HDR_B0};
  endfunction

  // sender: optional gap, then hold the beat until it is taken
  task automatic send_beat(input logic [31:0] w, input logic f, input logic l,
                           input exp_kind_t kind = EXP_MODEL);
    point_t p;
    bit hit;
    bit rdy;
    hit = convert_word(w, f, l, p);
    case (kind)
      EXP_MODEL: if (hit) point_q.insert(point_q.size(), p);
      EXP_SEQERR: point_q.insert(point_q.size(), point_t'{serr: 1'b1, default: '0});
      EXP_DONE: point_q.insert(point_q.size(), point_t'{fdone: 1'b1, default: '0});
      default: ;
    endcase
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_word <= w;
    in_first_of_datagram <= f;
    in_last_of_datagram <= l;
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (point_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_range();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return {1'b0, 8'($urandom_range(0, 20)), 23'($urandom())};
      default: return {1'b0, 8'($urandom_range(110, 145)), 23'($urandom())};
    endcase
  endfunction

  // result side
  int     stall = 0;
  logic   out_fire = 1'b0;
  point_t seen;

  always @(negedge clk) begin
    out_fire = out_valid && out_ready;
    seen = '{out_point_valid, out_coord_x, out_coord_y, out_coord_z, out_ring, out_column,
             out_sequence_error, out_frame_done};
  end

  always @(posedge clk) begin
    if (out_fire) begin
      if (point_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %p", seen);
      end else begin
        point_t want;
        want = point_q.pop_front();
        if (want !== seen) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p actual %p", want, seen);
        end
      end
    end
    if (!rst_n || quiet) out_ready <= 1'b1;
    else if (stall > 0) begin
      stall <= stall - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall <= $urandom_range(0, 7);
      out_ready <= 1'b0;
    end else out_ready <= 1'b1;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

  row_t directed[] = '{
    '{32'h3f800000, 1'b0, 1'b0, EXP_NONE},
    '{32'h3f636261, 1'b1, 1'b0, EXP_NONE},
    '{32'h3f800000, 1'b0, 1'b1, EXP_NONE},
    '{32'h00706564, 1'b1, 1'b0, EXP_NONE},
    '{32'h3f800000, 1'b0, 1'b0, EXP_MODEL},
    '{32'h7f800000, 1'b0, 1'b0, EXP_MODEL},
    '{32'h7fc00000, 1'b0, 1'b0, EXP_NONE},
    '{32'hff800000, 1'b0, 1'b0, EXP_NONE},
    '{32'h00000000, 1'b0, 1'b0, EXP_NONE},
    '{32'h80000000, 1'b0, 1'b0, EXP_NONE},
    '{32'h00000001, 1'b0, 1'b0, EXP_MODEL},
    '{32'hbf800000, 1'b0, 1'b0, EXP_NONE},
    '{32'h7f7fffff, 1'b0, 1'b0, EXP_MODEL},
    '{32'h3f800000, 1'b0, 1'b1, EXP_MODEL},
    '{32'h05706564, 1'b1, 1'b0, EXP_SEQERR},
    '{32'h40000000, 1'b0, 1'b1, EXP_NONE},
    '{32'h01706564, 1'b1, 1'b1, EXP_NONE},
    '{32'h21706564, 1'b1, 1'b1, EXP_DONE},
    '{32'h00706564, 1'b1, 1'b0, EXP_NONE},
    '{32'h01706564, 1'b1, 1'b0, EXP_NONE},
    '{32'h42c80000, 1'b0, 1'b1, EXP_MODEL},
    '{32'h21706564, 1'b1, 1'b0, EXP_NONE},
    '{32'h40000000, 1'b0, 1'b0, EXP_MODEL},
    '{32'h46fffe00, 1'b0, 1'b1, EXP_MODEL}
  };

  initial begin
    int n;
    seq_expected = '0;
    in_depth = 1'b0;
    final_pkt = 1'b0;
    row_cnt = '0;
    col_cnt = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i])
      send_beat(directed[i].word, directed[i].first, directed[i].last, directed[i].kind);
    drain();

    // sequence byte wraps past 255
    for (int s = 0; s < 256; s++) send_beat(header(8'(s)), 1'b1, 1'b1);
    send_beat(header(8'h00), 1'b1, 1'b0);
    send_beat(rand_range(), 1'b0, 1'b1);
    send_beat(header(FINAL_SEQ), 1'b1, 1'b1);
    drain();

    // random datagrams
    n = 0;
    while (n < 110) begin
      int len;
      if (n > 90) quiet = 1'b1;
      len = $urandom_range(0, 6);
      case ($urandom_range(0, 9))
        0: begin
          send_beat($urandom(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          n++;
        end
        1: begin
          send_beat(header(8'($urandom())), 1'b1, len == 0);
          n++;
        end
        2, 3: begin
          send_beat(header(FINAL_SEQ), 1'b1, len == 0);
          for (int j = 0; j < len; j++) send_beat(rand_range(), 1'b0, j == len - 1);
          n += len + 1;
        end
        default: begin
          send_beat(header(seq_expected), 1'b1, len == 0);
          for (int j = 0; j < len; j++)
            send_beat(rand_range(), $urandom_range(0, 30) == 0, j == len - 1);
          n += len + 1;
        end
      endcase
    end
    drain();
    repeat (30) @(posedge clk);
    if (errors == 0 && point_q.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
